// ===== hw/rtl/mbrtu_pkg.sv =====
// Shared types, codes and the CRC step for the Modbus RTU master engine.
package mbrtu_pkg;

  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int FRAME_BYTES     = 8;
  localparam int OUTQ_DEPTH      = 16;
  localparam int MAX_RESULTS     = 9;

  localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] TIMER_MAX   = 16'hFFFF;
  localparam logic [15:0] TURN_RESET  = 16'd10;
  localparam logic [15:0] REPLY_RESET = 16'd50;
  localparam int          EXC_BIT     = 7;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_RX   = 2'd2;

  localparam logic [2:0] OUT_TX       = 3'd0;
  localparam logic [2:0] OUT_ACCEPT   = 3'd1;
  localparam logic [2:0] OUT_REJECT   = 3'd2;
  localparam logic [2:0] OUT_DONE_OK  = 3'd3;
  localparam logic [2:0] OUT_DONE_ERR = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CRC       = 3'd1;
  localparam logic [2:0] ERR_SLAVE     = 3'd2;
  localparam logic [2:0] ERR_EXCEPTION = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT   = 3'd4;

  localparam logic [0:0] CFG_TURN  = 1'b0;
  localparam logic [0:0] CFG_REPLY = 1'b1;

  typedef enum logic [1:0] {ITEM_ENQ, ITEM_TICK, ITEM_RX} item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] read_value;
    logic [2:0]  error_code;
    logic [7:0]  done_slave;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } res_word_t;

  // One byte of CRC-16: the upper half is dropped before the byte is folded in.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {8'h00, c[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== hw/rtl/mbrtu_front.sv =====
// Front end: accepts input items, classifies them and queues them for the engine.
module mbrtu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_slave_addr,
  input  logic [7:0]         in_func_code,
  input  logic [15:0]        in_reg_addr,
  input  logic [15:0]        in_reg_value,
  input  logic [7:0]         in_rx_byte,
  output logic               item_valid,
  output mbrtu_pkg::item_t   item,
  input  logic               item_take
);

  mbrtu_pkg::item_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       wr;
  logic       rd;
  mbrtu_pkg::item_t cls;

  always_comb begin
    keep = 1'b1;
    cls.kind = mbrtu_pkg::ITEM_ENQ;
    case (in_req_type)
      mbrtu_pkg::REQ_ENQ:  cls.kind = mbrtu_pkg::ITEM_ENQ;
      mbrtu_pkg::REQ_TICK: cls.kind = mbrtu_pkg::ITEM_TICK;
      mbrtu_pkg::REQ_RX:   cls.kind = mbrtu_pkg::ITEM_RX;
      default:             keep = 1'b0; // unused request code: taken and dropped
    endcase
    cls.slave     = in_slave_addr;
    cls.func      = in_func_code;
    cls.reg_addr  = in_reg_addr;
    cls.reg_value = in_reg_value;
    cls.rx_byte   = in_rx_byte;
  end

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign wr         = push && !full && keep;
  assign rd         = item_take && item_valid;

  always_comb begin
    wr_ptr_nxt = wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hw/rtl/mbrtu_outq.sv =====
// Result queue between the engine and the result channel.
module mbrtu_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr,
  input  mbrtu_pkg::res_word_t   wdata,
  input  logic                   pop,
  output logic                   empty,
  output mbrtu_pkg::res_word_t   rdata,
  output logic [$clog2(mbrtu_pkg::OUTQ_DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(mbrtu_pkg::OUTQ_DEPTH);
  localparam int CW = $clog2(mbrtu_pkg::OUTQ_DEPTH + 1);

  mbrtu_pkg::res_word_t mem_r [mbrtu_pkg::OUTQ_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd;

  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];
  assign count = cnt_r;
  assign rd    = pop && !empty;

  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CW'(wr) - CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/mbrtu_back.sv =====
// Back end: command ring, frame transmit with CRC, reply collection and checking.
module mbrtu_back #(
  parameter int QUEUE_DEPTH = mbrtu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [15:0]            turn_limit,
  input  logic [15:0]            reply_limit,
  input  logic                   item_valid,
  input  mbrtu_pkg::item_t       item,
  output logic                   item_take,
  input  logic [$clog2(mbrtu_pkg::OUTQ_DEPTH+1)-1:0] oq_count,
  output logic                   oq_wr,
  output mbrtu_pkg::res_word_t   oq_wdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int OCW = $clog2(mbrtu_pkg::OUTQ_DEPTH + 1);
  localparam logic [OCW-1:0] OQ_ROOM = OCW'(mbrtu_pkg::OUTQ_DEPTH - mbrtu_pkg::MAX_RESULTS);
  localparam logic [PW-1:0]  PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]  CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [3:0]     RBYTES = 4'(mbrtu_pkg::FRAME_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_VERIFY, S_SENDCHK, S_LOAD, S_FCRC, S_TX, S_END
  } state_t;
  typedef enum logic [1:0] {M_IDLE, M_TURN, M_REPLY} mode_t;

  mbrtu_pkg::cmd_t mem_r [QUEUE_DEPTH];
  mbrtu_pkg::cmd_t rd_r;

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    qcnt_r, qcnt_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [3:0]       rcnt_r, rcnt_nxt;
  logic [7:0]       buf_r [8];
  logic [7:0]       buf_nxt [8];
  logic [QUEUE_DEPTH-1:0] retry_r, retry_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [7:0]       frame_r [6];
  logic [7:0]       frame_nxt [6];
  logic             pend_v_r, pend_v_nxt;
  mbrtu_pkg::result_t pend_r, pend_nxt;

  logic             mem_we;
  logic             emit_v;
  mbrtu_pkg::result_t emit_res;
  logic             do_fail, do_ok, do_pop;
  logic [2:0]       fail_err;
  logic [15:0]      tinc;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    qcnt_nxt   = qcnt_r;
    timer_nxt  = timer_r;
    rcnt_nxt   = rcnt_r;
    buf_nxt    = buf_r;
    retry_nxt  = retry_r;
    crc_nxt    = crc_r;
    idx_nxt    = idx_r;
    frame_nxt  = frame_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    mem_we     = 1'b0;
    item_take  = 1'b0;
    emit_v     = 1'b0;
    emit_res   = '0;
    do_fail    = 1'b0;
    do_ok      = 1'b0;
    do_pop     = 1'b0;
    fail_err   = mbrtu_pkg::ERR_NONE;
    tinc       = (timer_r != mbrtu_pkg::TIMER_MAX) ? timer_r + 16'd1 : timer_r;

    case (state_r)
      S_IDLE: begin
        // start only when the result queue can take a whole item's results
        if (item_valid && oq_count <= OQ_ROOM) begin
          item_take = 1'b1;
          state_nxt = S_SENDCHK;
          case (item.kind)
            mbrtu_pkg::ITEM_ENQ: begin
              emit_v = 1'b1;
              if (qcnt_r == CNT_FULL) begin
                emit_res.kind = mbrtu_pkg::OUT_REJECT;
              end else begin
                emit_res.kind     = mbrtu_pkg::OUT_ACCEPT;
                mem_we            = 1'b1;
                retry_nxt[head_r] = 1'b0;
                head_nxt          = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
                qcnt_nxt          = qcnt_r + 1'b1;
              end
            end
            mbrtu_pkg::ITEM_TICK: begin
              if (mode_r == M_TURN) begin
                timer_nxt = tinc;
                if (tinc > turn_limit) do_pop = 1'b1;
              end else if (mode_r == M_REPLY) begin
                timer_nxt = tinc;
                if (rcnt_r == 4'd0 && tinc > reply_limit) begin
                  do_fail  = 1'b1;
                  fail_err = mbrtu_pkg::ERR_TIMEOUT;
                end
              end
            end
            mbrtu_pkg::ITEM_RX: begin
              if (mode_r == M_REPLY && rcnt_r < RBYTES) begin
                buf_nxt[rcnt_r[2:0]] = item.rx_byte;
                rcnt_nxt = rcnt_r + 4'd1;
                if (rcnt_r == RBYTES - 4'd1) begin
                  state_nxt = S_CHK;
                  crc_nxt   = mbrtu_pkg::CRC_PRESET;
                  idx_nxt   = 3'd0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        crc_nxt = mbrtu_pkg::crc_byte(crc_r, buf_r[idx_r]);
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd5) state_nxt = S_VERIFY;
      end
      S_VERIFY: begin
        state_nxt = S_SENDCHK;
        if (buf_r[6] != crc_r[7:0] || buf_r[7] != crc_r[15:8]) begin
          do_fail  = 1'b1;
          fail_err = mbrtu_pkg::ERR_CRC;
        end else if (buf_r[0] != rd_r.slave) begin
          do_fail  = 1'b1;
          fail_err = mbrtu_pkg::ERR_SLAVE;
        end else if (buf_r[1][mbrtu_pkg::EXC_BIT]) begin
          do_fail  = 1'b1;
          fail_err = mbrtu_pkg::ERR_EXCEPTION;
        end else begin
          do_ok = 1'b1;
        end
      end
      S_SENDCHK: begin
        state_nxt = (mode_r == M_IDLE && qcnt_r != '0) ? S_LOAD : S_END;
      end
      S_LOAD: begin
        frame_nxt[0] = rd_r.slave;
        frame_nxt[1] = rd_r.func;
        frame_nxt[2] = rd_r.reg_addr[15:8];
        frame_nxt[3] = rd_r.reg_addr[7:0];
        frame_nxt[4] = rd_r.reg_value[15:8];
        frame_nxt[5] = rd_r.reg_value[7:0];
        crc_nxt      = mbrtu_pkg::CRC_PRESET;
        idx_nxt      = 3'd0;
        timer_nxt    = 16'd0;
        rcnt_nxt     = 4'd0;
        mode_nxt     = (rd_r.slave == 8'd0) ? M_TURN : M_REPLY;
        state_nxt    = S_FCRC;
      end
      S_FCRC: begin
        crc_nxt = mbrtu_pkg::crc_byte(crc_r, frame_r[idx_r]);
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd5) begin
          idx_nxt   = 3'd0;
          state_nxt = S_TX;
        end
      end
      S_TX: begin
        emit_v        = 1'b1;
        emit_res.kind = mbrtu_pkg::OUT_TX;
        case (idx_r)
          3'd6:    emit_res.tx_byte = crc_r[7:0];
          3'd7:    emit_res.tx_byte = crc_r[15:8];
          default: emit_res.tx_byte = frame_r[idx_r];
        endcase
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd7) state_nxt = S_END;
      end
      S_END: begin
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // first error arms the retry, the second one completes the command
    if (do_fail) begin
      mode_nxt = M_IDLE;
      if (!retry_r[tail_r]) begin
        retry_nxt[tail_r] = 1'b1;
      end else begin
        emit_v              = 1'b1;
        emit_res.kind       = mbrtu_pkg::OUT_DONE_ERR;
        emit_res.error_code = fail_err;
        emit_res.done_slave = rd_r.slave;
        do_pop              = 1'b1;
      end
    end
    if (do_ok) begin
      emit_v              = 1'b1;
      emit_res.kind       = mbrtu_pkg::OUT_DONE_OK;
      emit_res.read_value = {buf_r[3], buf_r[4]};
      emit_res.done_slave = rd_r.slave;
      do_pop              = 1'b1;
    end
    if (do_pop) begin
      mode_nxt = M_IDLE;
      if (qcnt_r != '0) begin
        tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
        qcnt_nxt = qcnt_r - 1'b1;
      end
    end

    // one result is held back so the final one of the item can carry last
    if (emit_v) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_res;
    end
    oq_wr          = pend_v_r && (emit_v || state_r == S_END);
    oq_wdata.res   = pend_r;
    oq_wdata.last  = (state_r == S_END);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      qcnt_r   <= '0;
      timer_r  <= 16'd0;
      rcnt_r   <= 4'd0;
      idx_r    <= 3'd0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      qcnt_r   <= qcnt_nxt;
      timer_r  <= timer_nxt;
      rcnt_r   <= rcnt_nxt;
      idx_r    <= idx_nxt;
      pend_v_r <= pend_v_nxt;
    end
    buf_r   <= buf_nxt;
    retry_r <= retry_nxt;
    crc_r   <= crc_nxt;
    frame_r <= frame_nxt;
    pend_r  <= pend_nxt;
  end

  // command ring: written at the head, tail entry read through the rd_r register
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[head_r] <= '{slave: item.slave, func: item.func,
                         reg_addr: item.reg_addr, reg_value: item.reg_value};
    end
    rd_r <= mem_r[tail_r];
  end

endmodule

// ===== hw/rtl/modbus_rtu_master_transaction_engine_unit.sv =====
// Modbus RTU master: top level with configuration registers.
// Input channel: push/full with in_req_type and the command or byte fields.
//   Enqueue items add a command to the ring, tick items advance the wait
//   timer, received-byte items fill the reply buffer.
// Result channel: empty/pop; each item yields zero to nine results, the last
//   of them flagged by out_last. A two-item input queue and a sixteen-entry
//   result queue decouple the engine from both sides.
// Engine steps per item: a frame that goes out is first run through a
//   byte-wise CRC over its six bytes and then transmitted byte by byte, and
//   a full reply is checked by a CRC over its first six bytes.
//   The engine takes one item at a time; an item waits until the result
//   queue has room for nine results.
// Stalling the result side fills the result queue, then the input queue,
//   then raises full; nothing is lost.
// Reset (rst_n low, synchronous) empties the command ring and both queues,
//   sets the link idle and loads turnaround 10 and reply limit 50 ticks.
// Configuration: APB-style writes at 0 (turnaround) and 4 (reply limit),
//   made while the block is idle.
module modbus_rtu_master_transaction_engine_unit #(
  parameter int QUEUE_DEPTH = mbrtu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_slave_addr,
  input  logic [7:0]  in_func_code,
  input  logic [15:0] in_reg_addr,
  input  logic [15:0] in_reg_value,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [15:0] out_read_value,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_done_slave,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] turn_r;
  logic [15:0] reply_r;
  logic        cfg_we;

  logic                 item_valid;
  mbrtu_pkg::item_t     item;
  logic                 item_take;
  logic                 oq_wr;
  mbrtu_pkg::res_word_t oq_wdata;
  mbrtu_pkg::res_word_t oq_rdata;
  logic [$clog2(mbrtu_pkg::OUTQ_DEPTH+1)-1:0] oq_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == mbrtu_pkg::CFG_REPLY) ? {16'd0, reply_r} : {16'd0, turn_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r  <= mbrtu_pkg::TURN_RESET;
      reply_r <= mbrtu_pkg::REPLY_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == mbrtu_pkg::CFG_REPLY) reply_r <= pwdata[15:0];
      else                                  turn_r  <= pwdata[15:0];
    end
  end

  mbrtu_front u_front (
    .clk, .rst_n, .push, .full,
    .in_req_type, .in_slave_addr, .in_func_code,
    .in_reg_addr, .in_reg_value, .in_rx_byte,
    .item_valid, .item, .item_take
  );

  mbrtu_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n,
    .turn_limit(turn_r), .reply_limit(reply_r),
    .item_valid, .item, .item_take,
    .oq_count, .oq_wr, .oq_wdata
  );

  mbrtu_outq u_outq (
    .clk, .rst_n,
    .wr(oq_wr), .wdata(oq_wdata), .pop, .empty,
    .rdata(oq_rdata), .count(oq_count)
  );

  assign out_kind       = oq_rdata.res.kind;
  assign out_tx_byte    = oq_rdata.res.tx_byte;
  assign out_read_value = oq_rdata.res.read_value;
  assign out_error_code = oq_rdata.res.error_code;
  assign out_done_slave = oq_rdata.res.done_slave;
  assign out_last       = oq_rdata.last;

endmodule

// ===== hw/rtl/mbrtu_checker.sv =====
// Port-level checks for the Modbus RTU master, bound to the top level.
module mbrtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_tx_byte,
  input logic [2:0]  out_error_code
);

  a_tx_only_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != mbrtu_pkg::OUT_TX) |-> out_tx_byte == 8'd0)
    else $error("tx byte set on a non-transmit result");

  a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == mbrtu_pkg::OUT_DONE_OK) |-> out_error_code == mbrtu_pkg::ERR_NONE)
    else $error("error code on a successful completion");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("results present after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind)))
    else $error("stalled result changed");

endmodule

bind modbus_rtu_master_transaction_engine_unit mbrtu_checker u_mbrtu_checker (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_tx_byte, .out_error_code
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the Modbus RTU master transaction engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = mbrtu_pkg::DEF_QUEUE_DEPTH;
  localparam int FRAME_BYTES = mbrtu_pkg::FRAME_BYTES;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE = 40;

  typedef enum logic [1:0] {LINK_IDLE, LINK_TURN, LINK_REPLY} link_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
    logic [7:0]  rx_byte;
  } bus_item_t;

  logic        clk, rst_n;
  logic        push, full, empty, pop;
  logic [1:0]  in_req_type;
  logic [7:0]  in_slave_addr, in_func_code, in_rx_byte;
  logic [15:0] in_reg_addr, in_reg_value;
  logic [2:0]  out_kind, out_error_code;
  logic [7:0]  out_tx_byte, out_done_slave;
  logic [15:0] out_read_value;
  logic        out_last;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  modbus_rtu_master_transaction_engine_unit u_top (.*);

  // Predicted engine state
  logic [15:0] turn_limit, reply_limit;
  logic [7:0]  cq_slave [DEPTH];
  logic [7:0]  cq_func  [DEPTH];
  logic [15:0] cq_reg   [DEPTH];
  logic [15:0] cq_val   [DEPTH];
  logic        cq_retry [DEPTH];
  int          q_head, q_tail, q_count, reply_cnt;
  link_t       link;
  logic [15:0] wait_ticks;
  logic [7:0]  reply_bytes [FRAME_BYTES];

  mbrtu_pkg::res_word_t expected_results[$];
  mbrtu_pkg::res_word_t step_results[$];

  int  mismatches, idle_cycles;
  bit  snd_idle, rcv_stall, rcv_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] frame_crc(input logic [7:0] b [FRAME_BYTES]);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < 6; i++) begin
      c = {8'h00, c[7:0] ^ b[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void add_result(input logic [2:0] kind, input logic [7:0] tx,
                                     input logic [15:0] val, input logic [2:0] err,
                                     input logic [7:0] slv);
    mbrtu_pkg::res_word_t r;
    r.res.kind = kind;
    r.res.tx_byte = tx;
    r.res.read_value = val;
    r.res.error_code = err;
    r.res.done_slave = slv;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void drop_command();
    if (q_count > 0) begin
      q_tail = (q_tail + 1) % DEPTH;
      q_count--;
    end
    link = LINK_IDLE;
  endfunction

  function automatic void command_failed(input logic [2:0] err);
    link = LINK_IDLE;
    if (!cq_retry[q_tail]) begin
      cq_retry[q_tail] = 1'b1;
    end else begin
      add_result(mbrtu_pkg::OUT_DONE_ERR, 8'h00, 16'h0000, err, cq_slave[q_tail]);
      drop_command();
    end
  endfunction

  function automatic void judge_reply();
    logic [15:0] c;
    c = frame_crc(reply_bytes);
    if (reply_bytes[6] != c[7:0] || reply_bytes[7] != c[15:8])
      command_failed(mbrtu_pkg::ERR_CRC);
    else if (reply_bytes[0] != cq_slave[q_tail]) command_failed(mbrtu_pkg::ERR_SLAVE);
    else if (reply_bytes[1][mbrtu_pkg::EXC_BIT]) command_failed(mbrtu_pkg::ERR_EXCEPTION);
    else begin
      add_result(mbrtu_pkg::OUT_DONE_OK, 8'h00, {reply_bytes[3], reply_bytes[4]},
                 mbrtu_pkg::ERR_NONE, cq_slave[q_tail]);
      drop_command();
    end
  endfunction

  function automatic void predict_engine(input bus_item_t it);
    logic [7:0]  f [FRAME_BYTES];
    logic [15:0] c;
    step_results.delete();
    case (it.req)
      mbrtu_pkg::REQ_ENQ: begin
        if (q_count >= DEPTH) begin
          add_result(mbrtu_pkg::OUT_REJECT, 8'h00, 16'h0000, mbrtu_pkg::ERR_NONE, 8'h00);
        end else begin
          cq_slave[q_head] = it.slave;
          cq_func[q_head]  = it.func;
          cq_reg[q_head]   = it.reg_addr;
          cq_val[q_head]   = it.reg_value;
          cq_retry[q_head] = 1'b0;
          q_head = (q_head + 1) % DEPTH;
          q_count++;
          add_result(mbrtu_pkg::OUT_ACCEPT, 8'h00, 16'h0000, mbrtu_pkg::ERR_NONE, 8'h00);
        end
      end
      mbrtu_pkg::REQ_TICK: begin
        if (link != LINK_IDLE) begin
          if (wait_ticks != mbrtu_pkg::TIMER_MAX) wait_ticks++;
          if (link == LINK_TURN) begin
            if (wait_ticks > turn_limit) drop_command();
          end else if (reply_cnt == 0 && wait_ticks > reply_limit) begin
            command_failed(mbrtu_pkg::ERR_TIMEOUT);
          end
        end
      end
      mbrtu_pkg::REQ_RX: begin
        if (link == LINK_REPLY && reply_cnt < FRAME_BYTES) begin
          reply_bytes[reply_cnt] = it.rx_byte;
          reply_cnt++;
          if (reply_cnt == FRAME_BYTES) judge_reply();
        end
      end
      default: ;
    endcase
    if (link == LINK_IDLE && q_count > 0) begin
      f[0] = cq_slave[q_tail];
      f[1] = cq_func[q_tail];
      f[2] = cq_reg[q_tail][15:8];
      f[3] = cq_reg[q_tail][7:0];
      f[4] = cq_val[q_tail][15:8];
      f[5] = cq_val[q_tail][7:0];
      f[6] = 8'h00;
      f[7] = 8'h00;
      c = frame_crc(f);
      f[6] = c[7:0];
      f[7] = c[15:8];
      for (int i = 0; i < FRAME_BYTES; i++)
        add_result(mbrtu_pkg::OUT_TX, f[i], 16'h0000, mbrtu_pkg::ERR_NONE, 8'h00);
      wait_ticks = 16'h0000;
      reply_cnt = 0;
      link = (f[0] == 8'h00) ? LINK_TURN : LINK_REPLY;
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // Called at a falling edge, returns at a falling edge.
  task automatic send_item(input bus_item_t it);
    if (snd_idle && $urandom_range(0, 99) < 53) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    push          <= 1'b1;
    in_req_type   <= it.req;
    in_slave_addr <= it.slave;
    in_func_code  <= it.func;
    in_reg_addr   <= it.reg_addr;
    in_reg_value  <= it.reg_value;
    in_rx_byte    <= it.rx_byte;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_engine(it);
    @(negedge clk);
  endtask

  function automatic bus_item_t noise_item(input logic [1:0] req);
    bus_item_t it;
    it.req       = req;
    it.slave     = 8'($urandom);
    it.func      = 8'($urandom);
    it.reg_addr  = 16'($urandom);
    it.reg_value = 16'($urandom);
    it.rx_byte   = 8'($urandom);
    return it;
  endfunction

  task automatic enqueue(input logic [7:0] slv);
    bus_item_t it;
    it = noise_item(mbrtu_pkg::REQ_ENQ);
    it.slave = slv;
    send_item(it);
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(noise_item(mbrtu_pkg::REQ_TICK));
  endtask

  task automatic rx_bytes(input logic [7:0] b [FRAME_BYTES], input int from, input int upto);
    bus_item_t it;
    for (int i = from; i < upto; i++) begin
      it = noise_item(mbrtu_pkg::REQ_RX);
      it.rx_byte = b[i];
      send_item(it);
    end
  endtask

  // flaw: 0 clean, 1 bad crc, 2 wrong slave, 3 exception
  function automatic void build_reply(input int flaw, output logic [7:0] b [FRAME_BYTES]);
    logic [15:0] c;
    foreach (b[i]) b[i] = 8'($urandom);
    b[0] = cq_slave[q_tail];
    if (flaw == 2) b[0] = b[0] ^ 8'($urandom_range(1, 255));
    b[1][mbrtu_pkg::EXC_BIT] = (flaw == 3);
    c = frame_crc(b);
    b[6] = c[7:0];
    b[7] = c[15:8] ^ ((flaw == 1) ? 8'($urandom_range(1, 255)) : 8'h00);
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() > 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [15:0] value);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready) begin
      if (idx == mbrtu_pkg::CFG_TURN) turn_limit = value;
      else reply_limit = value;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One command-reply exchange shaped by the predicted link state.
  task automatic exchange(input bit allow_enq, input bit bcast_ok, input bit noisy);
    logic [7:0] b [FRAME_BYTES];
    int pick, gap;
    if (allow_enq && $urandom_range(0, 2) != 0)
      repeat ($urandom_range(1, 3))
        enqueue((bcast_ok && $urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    if (link == LINK_TURN) begin
      ticks(turn_limit + 1 - wait_ticks);
    end else if (link == LINK_REPLY) begin
      pick = noisy ? $urandom_range(0, 7) : 0;
      if (pick == 7 && reply_limit > 20) pick = 8;
      case (pick)
        7: ticks(reply_limit + 1 - wait_ticks);
        8: begin
          build_reply(0, b);
          gap = $urandom_range(1, 4);
          rx_bytes(b, reply_cnt, 3);
          ticks(gap);
          rx_bytes(b, reply_cnt, FRAME_BYTES);
        end
        default: begin
          build_reply((pick < 4) ? 0 : pick - 3, b);
          rx_bytes(b, reply_cnt, FRAME_BYTES);
        end
      endcase
    end
    if (noisy && $urandom_range(0, 3) == 0) send_item(noise_item(2'($urandom_range(1, 3))));
  endtask

  task automatic drain_commands();
    while (q_count > 0) exchange(1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_unicast_extremes();
    bus_item_t it;
    logic [7:0] b [FRAME_BYTES];
    it = '{req: mbrtu_pkg::REQ_ENQ, slave: 8'hFF, func: 8'hFF, reg_addr: 16'hFFFF,
           reg_value: 16'hFFFF, rx_byte: 8'hFF};
    send_item(it);
    it = '{req: mbrtu_pkg::REQ_ENQ, slave: 8'h01, func: 8'h00, reg_addr: 16'h0000,
           reg_value: 16'h0000, rx_byte: 8'h00};
    send_item(it);
    build_reply(0, b);
    b[3] = 8'hFF;
    b[4] = 8'hFF;
    {b[7], b[6]} = frame_crc(b);
    rx_bytes(b, 0, FRAME_BYTES);
    send_item(noise_item(2'd3));
    build_reply(0, b);
    rx_bytes(b, 0, FRAME_BYTES);
  endtask

  task automatic test_retry_and_timeout();
    logic [7:0] b [FRAME_BYTES];
    cfg_write(mbrtu_pkg::CFG_REPLY, 16'd0);
    enqueue(8'h11);
    build_reply(1, b);
    rx_bytes(b, 0, FRAME_BYTES);   // crc fail, resent
    ticks(1);                      // timeout on the retry ends it
    enqueue(8'h22);
    build_reply(2, b);
    rx_bytes(b, 0, FRAME_BYTES);
    build_reply(3, b);
    rx_bytes(b, 0, FRAME_BYTES);
  endtask

  task automatic test_broadcast();
    cfg_write(mbrtu_pkg::CFG_TURN, 16'd0);
    ticks(1);                      // tick while idle
    enqueue(8'h00);
    ticks(1);
  endtask

  task automatic test_queue_full();
    cfg_write(mbrtu_pkg::CFG_REPLY, 16'hFFFF);
    repeat (DEPTH + 1) enqueue(8'($urandom_range(1, 255)));
    ticks(3);                      // saturating limit never expires
    cfg_write(mbrtu_pkg::CFG_REPLY, 16'd0);
    while (q_count > 0) ticks(1);  // each command times out twice
  endtask

  task automatic run_phase(input logic [15:0] turn, input logic [15:0] rlim,
                           input bit s_idle, input bit r_stall, input bit pressure);
    int start;
    cfg_write(mbrtu_pkg::CFG_TURN, turn);
    cfg_write(mbrtu_pkg::CFG_REPLY, rlim);
    snd_idle = s_idle;
    rcv_stall = r_stall;
    if (pressure) begin
      fork
        begin
          rcv_hold = 1'b1;
          repeat (500) @(negedge clk);
          rcv_hold = 1'b0;
        end
      join_none
      repeat (2) enqueue(8'($urandom_range(1, 255)));
    end
    start = 0;
    while (start < 1) begin
      exchange(1'b1, turn < 20, 1'b1);
      if (pressure && start == 0) wait_drained();
      start++;
    end
    drain_commands();
    snd_idle = 1'b0;
    rcv_stall = 1'b0;
  endtask

  always @(negedge clk) pop <= rcv_hold ? 1'b0 : (!rcv_stall || $urandom_range(0, 99) >= 53);

  always @(posedge clk) begin
    mbrtu_pkg::res_word_t exp_r;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: kind %0d tx %h", out_kind, out_tx_byte);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_kind !== exp_r.res.kind || out_tx_byte !== exp_r.res.tx_byte ||
            out_read_value !== exp_r.res.read_value ||
            out_error_code !== exp_r.res.error_code ||
            out_done_slave !== exp_r.res.done_slave || out_last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d tx %h val %h err %0d slv %h last %b,",
                     exp_r.res.kind, exp_r.res.tx_byte, exp_r.res.read_value,
                     exp_r.res.error_code, exp_r.res.done_slave, exp_r.last,
                     " got %0d %h %h %0d %h %b", out_kind,
                     out_tx_byte, out_read_value, out_error_code, out_done_slave, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    {in_req_type, in_slave_addr, in_func_code, in_reg_addr, in_reg_value, in_rx_byte} = '0;
    {psel, penable, pwrite, paddr, pwdata} = '0;
    snd_idle = 1'b0;
    rcv_stall = 1'b0;
    rcv_hold = 1'b0;
    turn_limit = mbrtu_pkg::TURN_RESET;
    reply_limit = mbrtu_pkg::REPLY_RESET;
    q_head = 0;
    q_tail = 0;
    q_count = 0;
    reply_cnt = 0;
    wait_ticks = 16'h0000;
    link = LINK_IDLE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unicast_extremes();
    test_retry_and_timeout();
    test_broadcast();
    test_queue_full();
    run_phase(16'd2, 16'd3, 1'b0, 1'b0, 1'b1);
    run_phase(16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    run_phase(16'd5, 16'd10, 1'b1, 1'b1, 1'b0);

    settle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
